[rtl/stt_pkg.sv]
// shared types, constants and lookup functions of the source text tokenizer
package stt_pkg;

    localparam int LENGTH_BITS = 16;
    localparam int LINE_BITS   = 16;
    localparam int OFFSET_BITS = 32;
    localparam int MAX_TOKENS  = 3;
    localparam int KW_WINDOW   = 8;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX  = {LENGTH_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [LENGTH_BITS-1:0] HEX_MAX  = LENGTH_BITS'(2 + 16);
    localparam logic [LENGTH_BITS-1:0] BIN_MAX  = LENGTH_BITS'(3 + 64);

    // token kinds
    localparam logic [6:0] K_ERROR = 7'd0,  K_HEX = 7'd1,   K_BINARY = 7'd2, K_FLOAT = 7'd3;
    localparam logic [6:0] K_INT = 7'd4,    K_CHAR = 7'd5,  K_STRING = 7'd6, K_EOF = 7'd7;
    localparam logic [6:0] K_I8 = 7'd8,     K_I16 = 7'd9,   K_I32 = 7'd10,   K_I64 = 7'd11;
    localparam logic [6:0] K_U8 = 7'd12,    K_U16 = 7'd13,  K_U32 = 7'd14,   K_U64 = 7'd15;
    localparam logic [6:0] K_F32 = 7'd16,   K_F64 = 7'd17,  K_KCHAR = 7'd18, K_KSTRING = 7'd19;
    localparam logic [6:0] K_BOOL = 7'd20,  K_VOID = 7'd21, K_ENUM = 7'd22,  K_STRUCT = 7'd23;
    localparam logic [6:0] K_IF = 7'd24,    K_ELSE = 7'd25, K_WHILE = 7'd26, K_FOR = 7'd27;
    localparam logic [6:0] K_BREAK = 7'd28, K_CONTINUE = 7'd29, K_RETURN = 7'd30;
    localparam logic [6:0] K_BOOLLIT = 7'd31, K_IDENT = 7'd32;
    localparam logic [6:0] K_LBRACE = 7'd33, K_RBRACE = 7'd34, K_LPAREN = 7'd35;
    localparam logic [6:0] K_RPAREN = 7'd36, K_LBRACK = 7'd37, K_RBRACK = 7'd38;
    localparam logic [6:0] K_SEP = 7'd39, K_SCOPE = 7'd40, K_COLON = 7'd41, K_SEMI = 7'd42;
    localparam logic [6:0] K_ADD_EQ = 7'd43, K_INC = 7'd44, K_ADD = 7'd45;
    localparam logic [6:0] K_SUB_EQ = 7'd46, K_DEC = 7'd47, K_SUB = 7'd48;
    localparam logic [6:0] K_MUL_EQ = 7'd49, K_MUL = 7'd50, K_DIV_EQ = 7'd51, K_DIV = 7'd52;
    localparam logic [6:0] K_MOD_EQ = 7'd53, K_MOD = 7'd54, K_NOT_EQ_T = 7'd55, K_TILDE = 7'd56;
    localparam logic [6:0] K_XOR_EQ = 7'd57, K_XOR = 7'd58;
    localparam logic [6:0] K_AND_EQ = 7'd59, K_LAND = 7'd60, K_AND = 7'd61;
    localparam logic [6:0] K_OR_EQ = 7'd62, K_LOR = 7'd63, K_OR = 7'd64;
    localparam logic [6:0] K_NE = 7'd65, K_BANG = 7'd66, K_QUEST = 7'd67;
    localparam logic [6:0] K_SHL_EQ = 7'd68, K_SHL = 7'd69, K_LT = 7'd70;
    localparam logic [6:0] K_SHR_EQ = 7'd71, K_SHR = 7'd72, K_GT = 7'd73;
    localparam logic [6:0] K_EQ = 7'd74, K_ASSIGN = 7'd75;
    localparam logic [6:0] K_TO_OP2 = 7'h7F;

    // error kinds
    localparam logic [2:0] E_NONE = 3'd0, E_UNEXPECTED = 3'd1, E_HEX_WIDE = 3'd2;
    localparam logic [2:0] E_BIN_WIDE = 3'd3, E_NO_QUOTE = 3'd4, E_MULTILINE = 3'd5;
    localparam logic [2:0] E_UNTERMINATED = 3'd6;

    // control characters
    localparam logic [7:0] CH_NUL = 8'h00, CH_TAB = 8'h09, CH_NL = 8'h0A, CH_CR = 8'h0D;
    localparam logic [7:0] CH_DQUOTE = 8'h22, CH_QUOTE = 8'h27, CH_TICK = 8'h60;

    typedef enum logic [14:0] {
        M_IDLE    = 15'b000000000000001,
        M_SLASH   = 15'b000000000000010,
        M_COMMENT = 15'b000000000000100,
        M_NUM     = 15'b000000000001000,
        M_NUMDOT  = 15'b000000000010000,
        M_FLOAT   = 15'b000000000100000,
        M_HEX     = 15'b000000001000000,
        M_BIN     = 15'b000000010000000,
        M_STR     = 15'b000000100000000,
        M_CHAR1   = 15'b000001000000000,
        M_CHAR2   = 15'b000010000000000,
        M_IDENT   = 15'b000100000000000,
        M_OP1     = 15'b001000000000000,
        M_OP2     = 15'b010000000000000,
        M_TICK    = 15'b100000000000000
    } t_mode;

    typedef struct packed {
        logic [6:0]             kind;
        logic [2:0]             err;
        logic [LENGTH_BITS-1:0] len;
        logic [LINE_BITS-1:0]   line;
        logic [OFFSET_BITS-1:0] start;
        logic                   last;
    } t_tok;

    typedef struct packed {
        logic       vld;
        logic [7:0] a;
        logic [6:0] ka;
        logic [7:0] b;
        logic [6:0] kb;
        logic [6:0] single;
    } t_op;

    function automatic t_tok f_tok(input logic [6:0] kind, input logic [2:0] err,
                                   input logic [LENGTH_BITS-1:0] len,
                                   input logic [OFFSET_BITS-1:0] start,
                                   input logic [LINE_BITS-1:0] line);
        t_tok t;
        t.kind  = kind;
        t.err   = err;
        t.len   = len;
        t.line  = line;
        t.start = start;
        t.last  = 1'b0;
        return t;
    endfunction

    function automatic logic f_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic f_alpha(input logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z")) || (c == "_");
    endfunction

    function automatic logic f_hex(input logic [7:0] c);
        return f_digit(c) || ((c >= "A") && (c <= "F")) || ((c >= "a") && (c <= "f"));
    endfunction

    // operator table, keyed by the first character
    function automatic t_op f_op(input logic [7:0] c);
        t_op o;
        o = '{vld: 1'b1, a: "=", ka: K_ERROR, b: CH_NUL, kb: K_ERROR, single: K_ERROR};
        case (c)
            ":": begin o.a = ":"; o.ka = K_SCOPE; o.single = K_COLON; end
            "+": begin o.ka = K_ADD_EQ; o.b = "+"; o.kb = K_INC; o.single = K_ADD; end
            "-": begin o.ka = K_SUB_EQ; o.b = "-"; o.kb = K_DEC; o.single = K_SUB; end
            "*": begin o.ka = K_MUL_EQ; o.single = K_MUL; end
            "%": begin o.ka = K_MOD_EQ; o.single = K_MOD; end
            "~": begin o.ka = K_NOT_EQ_T; o.single = K_TILDE; end
            "^": begin o.ka = K_XOR_EQ; o.single = K_XOR; end
            "&": begin o.ka = K_AND_EQ; o.b = "&"; o.kb = K_LAND; o.single = K_AND; end
            "|": begin o.ka = K_OR_EQ; o.b = "|"; o.kb = K_LOR; o.single = K_OR; end
            "!": begin o.ka = K_NE; o.single = K_BANG; end
            "=": begin o.ka = K_EQ; o.single = K_ASSIGN; end
            "<": begin o.a = "<"; o.ka = K_TO_OP2; o.single = K_LT; end
            ">": begin o.a = ">"; o.ka = K_TO_OP2; o.single = K_GT; end
            default: o.vld = 1'b0;
        endcase
        return o;
    endfunction

    // window holds the first lexeme bytes, first byte lowest, unused bytes zero
    function automatic logic [6:0] f_keyword(input logic [63:0] w,
                                             input logic [LENGTH_BITS-1:0] n);
        logic [6:0] k;
        k = K_IDENT;
        if (n == LENGTH_BITS'(2)) begin
            if (w == 64'("8i")) k = K_I8;
            else if (w == 64'("8u")) k = K_U8;
            else if (w == 64'("fi")) k = K_IF;
        end else if (n == LENGTH_BITS'(3)) begin
            if (w == 64'("61i")) k = K_I16;
            else if (w == 64'("23i")) k = K_I32;
            else if (w == 64'("46i")) k = K_I64;
            else if (w == 64'("61u")) k = K_U16;
            else if (w == 64'("23u")) k = K_U32;
            else if (w == 64'("46u")) k = K_U64;
            else if (w == 64'("23f")) k = K_F32;
            else if (w == 64'("46f")) k = K_F64;
            else if (w == 64'("rof")) k = K_FOR;
        end else if (n == LENGTH_BITS'(4)) begin
            if (w == 64'("rahc")) k = K_KCHAR;
            else if (w == 64'("loob")) k = K_BOOL;
            else if (w == 64'("diov")) k = K_VOID;
            else if (w == 64'("mune")) k = K_ENUM;
            else if (w == 64'("esle")) k = K_ELSE;
            else if (w == 64'("eurt")) k = K_BOOLLIT;
        end else if (n == LENGTH_BITS'(5)) begin
            if (w == 64'("elihw")) k = K_WHILE;
            else if (w == 64'("kaerb")) k = K_BREAK;
            else if (w == 64'("eslaf")) k = K_BOOLLIT;
        end else if (n == LENGTH_BITS'(6)) begin
            if (w == 64'("gnirts")) k = K_KSTRING;
            else if (w == 64'("tcurts")) k = K_STRUCT;
            else if (w == 64'("nruter")) k = K_RETURN;
        end else if (n == LENGTH_BITS'(8)) begin
            if (w == 64'("eunitnoc")) k = K_CONTINUE;
        end
        return k;
    endfunction

    function automatic logic [63:0] f_grow_win(input logic [63:0] w,
                                               input logic [LENGTH_BITS-1:0] n,
                                               input logic [7:0] c);
        logic [63:0] r;
        r = w;
        for (int i = 0; i < KW_WINDOW; i++) begin
            if (n == LENGTH_BITS'(i)) r[i*8 +: 8] = r[i*8 +: 8] | c;
        end
        return r;
    endfunction

    function automatic logic [LENGTH_BITS-1:0] f_grow_cnt(input logic [LENGTH_BITS-1:0] n);
        return (n < LEN_MAX) ? n + LENGTH_BITS'(1) : n;
    endfunction

endpackage

[rtl/stt_scan.sv]
// scanner state registers and the per-byte next-state and token logic
module stt_scan import stt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_end,
    output t_tok       o_tok [MAX_TOKENS],
    output logic [1:0] o_num
);

    t_mode                  r_mode, n_mode;
    logic [LINE_BITS-1:0]   r_line, n_line;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [OFFSET_BITS-1:0] r_start, n_start;
    logic [LENGTH_BITS-1:0] r_cnt, n_cnt;
    logic [63:0]            r_win, n_win;
    logic [7:0]             r_held, n_held;
    logic                   r_fin, n_fin;

    t_tok       toks [MAX_TOKENS];
    logic [1:0] nt;
    logic       used;
    logic       endf;
    t_op        op;
    logic [7:0] c;

    always_comb begin
        n_mode  = r_mode;
        n_line  = r_line;
        n_pos   = r_pos;
        n_start = r_start;
        n_cnt   = r_cnt;
        n_win   = r_win;
        n_held  = r_held;
        n_fin   = r_fin;
        nt      = 2'd0;
        used    = 1'b0;
        c       = i_byte;
        endf    = i_end || (i_byte == CH_NUL);
        op      = f_op(r_held);
        for (int i = 0; i < MAX_TOKENS; i++) toks[i] = '0;

        if (i_accept && !r_fin) begin
            if (endf) begin
                // flush the pending token, then the eof; a pending tick run is itself sent as the eof
                case (r_mode)
                    M_SLASH: begin
                        toks[nt] = f_tok(K_DIV, E_NONE, n_cnt, n_start, n_line); nt = nt + 2'd1;
                    end
                    M_NUM: begin
                        toks[nt] = f_tok(K_INT, E_NONE, n_cnt, n_start, n_line); nt = nt + 2'd1;
                    end
                    M_NUMDOT: begin
                        toks[nt] = f_tok(K_INT, E_NONE, n_cnt, n_start, n_line); nt = nt + 2'd1;
                        toks[nt] = f_tok(K_SEP, E_NONE, LENGTH_BITS'(1),
                                         r_pos - OFFSET_BITS'(1), n_line);
                        nt = nt + 2'd1;
                    end
                    M_FLOAT: begin
                        toks[nt] = f_tok(K_FLOAT, E_NONE, n_cnt, n_start, n_line); nt = nt + 2'd1;
                    end
                    M_HEX: begin
                        if (n_cnt > HEX_MAX)
                            toks[nt] = f_tok(K_ERROR, E_HEX_WIDE, n_cnt, n_start, n_line);
                        else
                            toks[nt] = f_tok(K_HEX, E_NONE, n_cnt, n_start, n_line);
                        nt = nt + 2'd1;
                    end
                    M_BIN: begin
                        toks[nt] = f_tok(K_ERROR, E_NO_QUOTE, n_cnt, n_start, n_line);
                        nt = nt + 2'd1;
                    end
                    M_STR: begin
                        toks[nt] = f_tok(K_ERROR, E_UNTERMINATED, n_cnt, n_start, n_line);
                        nt = nt + 2'd1;
                    end
                    M_CHAR1, M_CHAR2: begin
                        toks[nt] = f_tok(K_CHAR, E_NONE, n_cnt, n_start, n_line); nt = nt + 2'd1;
                    end
                    M_IDENT: begin
                        toks[nt] = f_tok(f_keyword(n_win, n_cnt), E_NONE, n_cnt, n_start, n_line);
                        nt = nt + 2'd1;
                    end
                    M_OP1: begin
                        if (op.vld)
                            toks[nt] = f_tok(op.single, E_NONE, n_cnt, n_start, n_line);
                        else
                            toks[nt] = f_tok(K_ERROR, E_UNEXPECTED, n_cnt, n_start, n_line);
                        nt = nt + 2'd1;
                    end
                    M_OP2: begin
                        toks[nt] = f_tok((r_held == "<") ? K_SHL : K_SHR, E_NONE,
                                         n_cnt, n_start, n_line);
                        nt = nt + 2'd1;
                    end
                    M_TICK: begin
                        toks[nt] = f_tok(K_EOF, E_NONE, n_cnt, n_start, n_line); nt = nt + 2'd1;
                    end
                    default: ;
                endcase
                if (r_mode != M_TICK) begin
                    toks[nt] = f_tok(K_EOF, E_NONE, '0, r_pos, n_line);
                    nt = nt + 2'd1;
                end
                n_fin  = 1'b1;
                n_mode = M_IDLE;
            end else begin
                // feed the byte to the pending token
                case (r_mode)
                    M_SLASH: begin
                        if (c == "/") begin
                            n_mode = M_COMMENT; used = 1'b1;
                        end else if (c == "=") begin
                            n_win = f_grow_win(n_win, n_cnt, c); n_cnt = f_grow_cnt(n_cnt);
                            toks[nt] = f_tok(K_DIV_EQ, E_NONE, n_cnt, n_start, n_line);
                            nt = nt + 2'd1; n_mode = M_IDLE; used = 1'b1;
                        end else begin
                            toks[nt] = f_tok(K_DIV, E_NONE, n_cnt, n_start, n_line);
                            nt = nt + 2'd1; n_mode = M_IDLE;
                        end
                    end
                    M_COMMENT: begin
                        if (c == CH_NL) n_mode = M_IDLE;
                        else used = 1'b1;
                    end
                    M_NUM: begin
                        if (f_digit(c)) begin
                            n_win = f_grow_win(n_win, n_cnt, c); n_cnt = f_grow_cnt(n_cnt);
                            used = 1'b1;
                        end else if (c == "x" && r_cnt == LENGTH_BITS'(1) && r_held == "0") begin
                            n_win = f_grow_win(n_win, n_cnt, c); n_cnt = f_grow_cnt(n_cnt);
                            n_mode = M_HEX; used = 1'b1;
                        end else if (c == ".") begin
                            n_mode = M_NUMDOT; used = 1'b1;
                        end else begin
                            toks[nt] = f_tok(K_INT, E_NONE, n_cnt, n_start, n_line);
                            nt = nt + 2'd1; n_mode = M_IDLE;
                        end
                    end
                    M_NUMDOT: begin
                        if (f_digit(c)) begin
                            n_win = f_grow_win(n_win, n_cnt, "."); n_cnt = f_grow_cnt(n_cnt);
                            n_win = f_grow_win(n_win, n_cnt, c); n_cnt = f_grow_cnt(n_cnt);
                            n_mode = M_FLOAT; used = 1'b1;
                        end else begin
                            // integer then the dot on its own
                            toks[nt] = f_tok(K_INT, E_NONE, n_cnt, n_start, n_line);
                            nt = nt + 2'd1;
                            toks[nt] = f_tok(K_SEP, E_NONE, LENGTH_BITS'(1),
                                             r_pos - OFFSET_BITS'(1), n_line);
                            nt = nt + 2'd1; n_mode = M_IDLE;
                        end
                    end
                    M_FLOAT: begin
                        if (f_digit(c)) begin
                            n_win = f_grow_win(n_win, n_cnt, c); n_cnt = f_grow_cnt(n_cnt);
                            used = 1'b1;
                        end else begin
                            toks[nt] = f_tok(K_FLOAT, E_NONE, n_cnt, n_start, n_line);
                            nt = nt + 2'd1; n_mode = M_IDLE;
                        end
                    end
                    M_HEX: begin
                        if (f_hex(c)) begin
                            n_win = f_grow_win(n_win, n_cnt, c); n_cnt = f_grow_cnt(n_cnt);
                            used = 1'b1;
                        end else begin
                            if (n_cnt > HEX_MAX)
                                toks[nt] = f_tok(K_ERROR, E_HEX_WIDE, n_cnt, n_start, n_line);
                            else
                                toks[nt] = f_tok(K_HEX, E_NONE, n_cnt, n_start, n_line);
                            nt = nt + 2'd1; n_mode = M_IDLE;
                        end
                    end
                    M_BIN: begin
                        if (c == "0" || c == "1") begin
                            n_win = f_grow_win(n_win, n_cnt, c); n_cnt = f_grow_cnt(n_cnt);
                            used = 1'b1;
                        end else if (c == CH_QUOTE) begin
                            n_win = f_grow_win(n_win, n_cnt, c); n_cnt = f_grow_cnt(n_cnt);
                            if (n_cnt > BIN_MAX)
                                toks[nt] = f_tok(K_ERROR, E_BIN_WIDE, n_cnt, n_start, n_line);
                            else
                                toks[nt] = f_tok(K_BINARY, E_NONE, n_cnt, n_start, n_line);
                            nt = nt + 2'd1; n_mode = M_IDLE; used = 1'b1;
                        end else begin
                            toks[nt] = f_tok(K_ERROR, E_NO_QUOTE, n_cnt, n_start, n_line);
                            nt = nt + 2'd1; n_mode = M_IDLE;
                        end
                    end
                    M_STR: begin
                        if (c == CH_DQUOTE) begin
                            n_win = f_grow_win(n_win, n_cnt, c); n_cnt = f_grow_cnt(n_cnt);
                            toks[nt] = f_tok(K_STRING, E_NONE, n_cnt, n_start, n_line);
                            nt = nt + 2'd1; n_mode = M_IDLE; used = 1'b1;
                        end else if (c == CH_NL) begin
                            toks[nt] = f_tok(K_ERROR, E_MULTILINE, n_cnt, n_start, n_line);
                            nt = nt + 2'd1; n_mode = M_IDLE;
                        end else begin
                            n_win = f_grow_win(n_win, n_cnt, c); n_cnt = f_grow_cnt(n_cnt);
                            used = 1'b1;
                        end
                    end
                    M_CHAR1: begin
                        n_win = f_grow_win(n_win, n_cnt, c); n_cnt = f_grow_cnt(n_cnt);
                        n_mode = M_CHAR2; used = 1'b1;
                    end
                    M_CHAR2: begin
                        n_win = f_grow_win(n_win, n_cnt, c); n_cnt = f_grow_cnt(n_cnt);
                        toks[nt] = f_tok(K_CHAR, E_NONE, n_cnt, n_start, n_line);
                        nt = nt + 2'd1; n_mode = M_IDLE; used = 1'b1;
                    end
                    M_IDENT: begin
                        if (c == CH_QUOTE && r_cnt == LENGTH_BITS'(1) && r_held == "b") begin
                            n_win = f_grow_win(n_win, n_cnt, c); n_cnt = f_grow_cnt(n_cnt);
                            n_mode = M_BIN; used = 1'b1;
                        end else if (f_alpha(c) || f_digit(c)) begin
                            n_win = f_grow_win(n_win, n_cnt, c); n_cnt = f_grow_cnt(n_cnt);
                            used = 1'b1;
                        end else begin
                            toks[nt] = f_tok(f_keyword(n_win, n_cnt), E_NONE, n_cnt, n_start,
                                             n_line);
                            nt = nt + 2'd1; n_mode = M_IDLE;
                        end
                    end
                    M_OP1: begin
                        if (!op.vld) begin
                            toks[nt] = f_tok(K_ERROR, E_UNEXPECTED, n_cnt, n_start, n_line);
                            nt = nt + 2'd1; n_mode = M_IDLE;
                        end else if (c == op.a) begin
                            n_win = f_grow_win(n_win, n_cnt, c); n_cnt = f_grow_cnt(n_cnt);
                            if (op.ka == K_TO_OP2) begin
                                n_mode = M_OP2;
                            end else begin
                                toks[nt] = f_tok(op.ka, E_NONE, n_cnt, n_start, n_line);
                                nt = nt + 2'd1; n_mode = M_IDLE;
                            end
                            used = 1'b1;
                        end else if (op.b != CH_NUL && c == op.b) begin
                            n_win = f_grow_win(n_win, n_cnt, c); n_cnt = f_grow_cnt(n_cnt);
                            toks[nt] = f_tok(op.kb, E_NONE, n_cnt, n_start, n_line);
                            nt = nt + 2'd1; n_mode = M_IDLE; used = 1'b1;
                        end else begin
                            toks[nt] = f_tok(op.single, E_NONE, n_cnt, n_start, n_line);
                            nt = nt + 2'd1; n_mode = M_IDLE;
                        end
                    end
                    M_OP2: begin
                        if (c == "=") begin
                            n_win = f_grow_win(n_win, n_cnt, c); n_cnt = f_grow_cnt(n_cnt);
                            toks[nt] = f_tok((r_held == "<") ? K_SHL_EQ : K_SHR_EQ, E_NONE,
                                             n_cnt, n_start, n_line);
                            nt = nt + 2'd1; used = 1'b1;
                        end else begin
                            toks[nt] = f_tok((r_held == "<") ? K_SHL : K_SHR, E_NONE,
                                             n_cnt, n_start, n_line);
                            nt = nt + 2'd1;
                        end
                        n_mode = M_IDLE;
                    end
                    M_TICK: begin
                        n_win = f_grow_win(n_win, n_cnt, c); n_cnt = f_grow_cnt(n_cnt);
                        used = 1'b1;
                    end
                    default: n_mode = M_IDLE;
                endcase

                // byte not taken by a pending token starts a new one, unless it is blank or a newline
                if (!used) begin
                    if (c == " " || c == CH_CR || c == CH_TAB) begin
                        n_mode = n_mode;
                    end else if (c == CH_NL) begin
                        if (n_line < LINE_MAX) n_line = n_line + LINE_BITS'(1);
                    end else begin
                        n_start = r_pos;
                        n_cnt   = LENGTH_BITS'(1);
                        n_win   = 64'(c);
                        n_held  = c;
                        n_mode  = M_IDLE;
                        case (c)
                            "/":       n_mode = M_SLASH;
                            CH_QUOTE:  n_mode = M_CHAR1;
                            CH_DQUOTE: n_mode = M_STR;
                            CH_TICK:   n_mode = M_TICK;
                            "{": begin toks[nt] = f_tok(K_LBRACE, E_NONE, n_cnt, n_start, n_line);
                                nt = nt + 2'd1; end
                            "}": begin toks[nt] = f_tok(K_RBRACE, E_NONE, n_cnt, n_start, n_line);
                                nt = nt + 2'd1; end
                            "(": begin toks[nt] = f_tok(K_LPAREN, E_NONE, n_cnt, n_start, n_line);
                                nt = nt + 2'd1; end
                            ")": begin toks[nt] = f_tok(K_RPAREN, E_NONE, n_cnt, n_start, n_line);
                                nt = nt + 2'd1; end
                            "[": begin toks[nt] = f_tok(K_LBRACK, E_NONE, n_cnt, n_start, n_line);
                                nt = nt + 2'd1; end
                            "]": begin toks[nt] = f_tok(K_RBRACK, E_NONE, n_cnt, n_start, n_line);
                                nt = nt + 2'd1; end
                            ".", ",": begin
                                toks[nt] = f_tok(K_SEP, E_NONE, n_cnt, n_start, n_line);
                                nt = nt + 2'd1;
                            end
                            ";": begin toks[nt] = f_tok(K_SEMI, E_NONE, n_cnt, n_start, n_line);
                                nt = nt + 2'd1; end
                            "?": begin toks[nt] = f_tok(K_QUEST, E_NONE, n_cnt, n_start, n_line);
                                nt = nt + 2'd1; end
                            default: begin
                                if (f_digit(c)) n_mode = M_NUM;
                                else if (f_alpha(c)) n_mode = M_IDENT;
                                else if (f_op(c).vld) n_mode = M_OP1;
                                else begin
                                    toks[nt] = f_tok(K_ERROR, E_UNEXPECTED, n_cnt, n_start,
                                                     n_line);
                                    nt = nt + 2'd1;
                                end
                            end
                        endcase
                    end
                end
                n_pos = r_pos + OFFSET_BITS'(1);
            end
            if (nt != 2'd0) toks[nt - 2'd1].last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_line  <= LINE_BITS'(1);
            r_pos   <= '0;
            r_start <= '0;
            r_cnt   <= '0;
            r_win   <= '0;
            r_held  <= '0;
            r_fin   <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_line  <= n_line;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_cnt   <= n_cnt;
            r_win   <= n_win;
            r_held  <= n_held;
            r_fin   <= n_fin;
        end
    end

    assign o_tok = toks;
    assign o_num = nt;

endmodule

[rtl/stt_outq.sv]
// result register holding one item's tokens, sent one per cycle while i_ready
module stt_outq import stt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_tok       i_tok [MAX_TOKENS],
    input  logic [1:0] i_num,
    output logic       o_free,
    output logic       o_valid,
    input  logic       i_ready,
    output t_tok       o_tok
);

    t_tok       r_tok [MAX_TOKENS];
    logic [1:0] r_num;
    logic [1:0] r_rd;
    logic       take_last;

    assign o_valid   = (r_num != 2'd0);
    assign take_last = o_valid && i_ready && (r_rd + 2'd1 == r_num);
    assign o_free    = (r_num == 2'd0) || take_last;
    assign o_tok     = r_tok[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_load) r_tok <= i_tok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num <= 2'd0;
            r_rd  <= 2'd0;
        end else if (i_load) begin
            r_num <= i_num;
            r_rd  <= 2'd0;
        end else if (take_last) begin
            r_num <= 2'd0;
            r_rd  <= 2'd0;
        end else if (o_valid && i_ready) begin
            r_rd <= r_rd + 2'd1;
        end
    end

    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_rd < r_num)
        else $error("read index past stored tokens");
    a_load_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("tokens loaded over undelivered ones");
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && i_num != 2'd0) |=> (o_valid && r_rd == 2'd0))
        else $error("loaded tokens not presented");
    a_drain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take_last && !i_load) |=> !o_valid)
        else $error("buffer not empty after last token");

endmodule

[rtl/source_text_tokenizer_unit.sv]
// source text tokenizer: byte stream in, token stream out
// latency: tokens of an accepted byte appear on the master side the next cycle
// throughput: one byte per cycle while i_m_tready is high and each byte yields
//   at most one token; a byte yielding more holds the output register until
//   its last token is taken, draining while the next byte is accepted
// reset: synchronous active low; scanner idle, line 1, offset 0, output empty
module source_text_tokenizer_unit import stt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side: one source byte per transaction
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] text_byte
    input  logic        i_s_tlast,   // end_of_text
    // master side: one token per transaction
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [79:0] o_m_tdata,   // token_kind, error_kind, lexeme_length,
                                     // line_number, start_offset, zero pad
    output logic        o_m_tlast    // last_of_run
);

    t_tok       scan_tok [MAX_TOKENS];
    logic [1:0] scan_num;
    logic       accept;
    logic       q_free;
    t_tok       out_tok;

    // a byte is taken whenever the result register is empty or emptying
    assign o_s_tready = q_free;
    assign accept     = i_s_tvalid && q_free;

    stt_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_s_tdata),
        .i_end    (i_s_tlast),
        .o_tok    (scan_tok),
        .o_num    (scan_num)
    );

    stt_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_tok   (scan_tok),
        .i_num   (scan_num),
        .o_free  (q_free),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_tok   (out_tok)
    );

    // pack fields from the lowest bit up
    assign o_m_tdata = {6'd0, out_tok.start, out_tok.line, out_tok.len,
                        out_tok.err, out_tok.kind};
    assign o_m_tlast = out_tok.last;

endmodule
